// File: hdl/gnhc_pkg.sv
// Package for the GC-normalised copy-state decoder: word types, register indexes,
// state machine encodings and the state-mean table. No dependencies.
`default_nettype none
package gnhc_pkg;

    localparam int NUM_STATES_DEF = 6;

    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;
    localparam int SCORE_W   = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_SWITCH_PENALTY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EMISSION_SCALE = 2'd1;

    localparam logic [CFG_W-1:0] SWITCH_PENALTY_RST = 16'd16384;
    localparam logic [CFG_W-1:0] EMISSION_SCALE_RST = 16'd16384;

    localparam logic signed [SCORE_W-1:0] INIT_OTHER = -32'sd8192;

    typedef struct packed {
        logic [15:0] gc_fraction;
        logic [23:0] read_depth;
        logic        first_bin;
    } t_in_word;

    typedef struct packed {
        logic signed [16:0] log2_ratio;
        logic [2:0]         copy_state;
    } t_out_word;

    typedef struct packed {
        logic signed [16:0] obs;
        logic               first_bin;
    } t_obs_word;

    typedef struct packed {
        logic [CFG_W-1:0] switch_penalty;
        logic [CFG_W-1:0] emission_scale;
    } t_cfg;

    typedef enum logic [2:0] {
        F_IDLE,
        F_DIV,
        F_NORM,
        F_LOG,
        F_PUSH
    } t_front_state;

    typedef enum logic [2:0] {
        B_IDLE,
        B_EMIT,
        B_ACS,
        B_BEST,
        B_DONE
    } t_back_state;

    // state means in Q5.11
    function automatic logic signed [16:0] mu_q11(input logic [2:0] k);
        logic signed [16:0] m;
        unique case (k)
            3'd0: m = -17'sd29261;
            3'd1: m = -17'sd2048;
            3'd2: m = 17'sd0;
            3'd3: m = 17'sd1198;
            3'd4: m = 17'sd2048;
            3'd5: m = 17'sd2707;
            3'd6: m = 17'sd3246;
            3'd7: m = 17'sd3701;
        endcase
        return m;
    endfunction

endpackage
`default_nettype wire

// File: hdl/gc_normalize_hmm_copy_state_core.sv
// Path from input word to result word: 42 divide steps, a normalise shift loop (its
// length set by the quotient's leading zeros), 20 log2 squarings, one push, then the
// queue and the decoder.
// The front end takes no new word until its bit-serial divider and log2 loop are
// through with the last one and it has been pushed; the decoder overlaps it.
// Reset: both registers return to 8.0, scores to the initial vector, queue empty.
// Holds the configuration registers; depends on gnhc_pkg and the gnhc_* modules.
`default_nettype none
module gc_normalize_hmm_copy_state_core #(
    parameter int NUM_STATES = gnhc_pkg::NUM_STATES_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_ready,
    input  wire gnhc_pkg::t_in_word                  i_in_data,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_ready,
    output gnhc_pkg::t_out_word                      o_out_data,
    input  wire logic                                i_cfg_wr_en,
    input  wire logic [gnhc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [gnhc_pkg::CFG_W-1:0]          i_cfg_data
);
    import gnhc_pkg::*;

    t_cfg      r_cfg;
    logic      push;
    logic      full;
    logic      pop;
    logic      empty;
    t_obs_word front_word;
    t_obs_word queue_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.switch_penalty <= SWITCH_PENALTY_RST;
            r_cfg.emission_scale <= EMISSION_SCALE_RST;
        end else if (i_cfg_wr_en) begin
            if (i_cfg_index == CFG_SWITCH_PENALTY) r_cfg.switch_penalty <= i_cfg_data;
            if (i_cfg_index == CFG_EMISSION_SCALE) r_cfg.emission_scale <= i_cfg_data;
        end
    end

    gnhc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_data  (i_in_data),
        .o_push  (push),
        .i_full  (full),
        .o_word  (front_word)
    );

    gnhc_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_word  (front_word),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_word  (queue_word)
    );

    gnhc_back #(
        .NUM_STATES (NUM_STATES)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_empty (empty),
        .i_word  (queue_word),
        .o_pop   (pop),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (o_out_data)
    );

endmodule
`default_nettype wire

// File: hdl/gnhc_front.sv
// Front end: accepts a bin, forms the GC-expected depth, divides bit-serially and
// takes log2 by normalise-and-square. Pushes the Q5.11 ratio word. Uses gnhc_pkg.
`default_nettype none
module gnhc_front (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire gnhc_pkg::t_in_word i_data,
    output logic                    o_push,
    input  wire logic               i_full,
    output gnhc_pkg::t_obs_word     o_word
);
    import gnhc_pkg::*;

    t_front_state r_state, n_state;

    logic [21:0] r_e;
    logic [21:0] r_rem;
    logic [41:0] r_q;
    logic [5:0]  r_cnt;
    logic        r_first;
    logic [42:0] r_w;
    logic [5:0]  r_p;
    logic [30:0] r_m;
    logic [19:0] r_f;

    logic [31:0] gsq;
    logic [22:0] e_sum;
    logic [21:0] e_cl;
    logic [38:0] dn;
    logic [22:0] trial;
    logic        ge;
    logic [41:0] q_next;
    logic [61:0] sq;
    logic [31:0] msq;
    logic signed [8:0]  pd;
    logic signed [28:0] v;
    logic signed [28:0] vr;
    logic signed [19:0] r_raw;
    logic signed [16:0] r_sat;

    always_comb begin
        gsq   = 32'(i_data.gc_fraction) * 32'(i_data.gc_fraction);
        e_sum = 23'd3276800 + 23'(i_data.gc_fraction) - 23'(gsq[31:17]);
        e_cl  = (e_sum < 23'd65536) ? 22'd65536 : e_sum[21:0];
        dn    = 39'(i_data.read_depth) * 39'd25600;
        trial = {r_rem, r_q[41]};
        ge    = trial >= {1'b0, r_e};
        q_next = {r_q[40:0], ge};
        sq    = 62'(r_m) * 62'(r_m);
        msq   = sq[61:30];
        pd    = $signed({3'b000, r_p}) - 9'sd24;
        v     = $signed({pd, 20'd0}) + $signed({9'd0, r_f}) - 29'sd6966590;
        vr    = v + 29'sd256;
        r_raw = 20'(vr >>> 9);
        if (r_raw < -20'sd65536) begin
            r_sat = -17'sd65536;
        end else if (r_raw > 20'sd65535) begin
            r_sat = 17'sd65535;
        end else begin
            r_sat = r_raw[16:0];
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            F_IDLE: if (i_valid) n_state = F_DIV;
            F_DIV:  if (r_cnt == 6'd41) n_state = F_NORM;
            F_NORM: if (r_w[42]) n_state = F_LOG;
            F_LOG:  if (r_cnt == 6'd19) n_state = F_PUSH;
            F_PUSH: if (!i_full) n_state = F_IDLE;
            default: n_state = F_IDLE;
        endcase
    end

    always_comb begin
        o_ready          = (r_state == F_IDLE);
        o_push           = (r_state == F_PUSH) && !i_full;
        o_word.obs       = r_sat;
        o_word.first_bin = r_first;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            F_IDLE: begin
                r_e     <= e_cl;
                r_rem   <= 22'(dn[38:18]);
                r_q     <= {dn[17:0], 24'd0};
                r_cnt   <= '0;
                r_first <= i_data.first_bin;
            end
            F_DIV: begin
                r_rem <= ge ? 22'(trial - {1'b0, r_e}) : trial[21:0];
                r_q   <= q_next;
                r_cnt <= r_cnt + 6'd1;
                r_w   <= 43'(q_next) + 43'd1678;
                r_p   <= 6'd42;
            end
            F_NORM: begin
                // shift until the top bit is set, tracking the msb position
                if (r_w[42]) begin
                    r_m   <= r_w[42:12];
                    r_f   <= '0;
                    r_cnt <= '0;
                end else begin
                    r_w <= {r_w[41:0], 1'b0};
                    r_p <= r_p - 6'd1;
                end
            end
            F_LOG: begin
                r_cnt <= r_cnt + 6'd1;
                r_f   <= {r_f[18:0], msq[31]};
                r_m   <= msq[31] ? msq[31:1] : msq[30:0];
            end
            F_PUSH: begin
                r_cnt <= r_cnt;
            end
            default: begin
                r_cnt <= r_cnt;
            end
        endcase
    end

endmodule
`default_nettype wire

// File: hdl/gnhc_fifo.sv
// Two-word queue between the front end and the decoder back end.
// Uses gnhc_pkg for the word type.
`default_nettype none
module gnhc_fifo (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_push,
    input  wire gnhc_pkg::t_obs_word i_word,
    output logic                     o_full,
    input  wire logic                i_pop,
    output logic                     o_empty,
    output gnhc_pkg::t_obs_word      o_word
);
    import gnhc_pkg::*;

    t_obs_word r_mem [2];
    logic      r_wr;
    logic      r_rd;
    logic [1:0] r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_word  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) r_wr <= ~r_wr;
            if (i_pop)  r_rd <= ~r_rd;
            r_count <= r_count + 2'(i_push) - 2'(i_pop);
        end
    end

endmodule
`default_nettype wire

// File: hdl/gnhc_back.sv
// Back end: per-state emission cost on one shared multiplier pair, parallel
// add-compare update, best-state pick and renormalisation. Uses gnhc_pkg.
`default_nettype none
module gnhc_back #(
    parameter int NUM_STATES = gnhc_pkg::NUM_STATES_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire gnhc_pkg::t_cfg      i_cfg,
    input  wire logic                i_empty,
    input  wire gnhc_pkg::t_obs_word i_word,
    output logic                     o_pop,
    output logic                     o_valid,
    input  wire logic                i_ready,
    output gnhc_pkg::t_out_word      o_data
);
    import gnhc_pkg::*;

    localparam int SW   = (NUM_STATES > 1) ? $clog2(NUM_STATES) : 1;
    localparam int KW   = $clog2(NUM_STATES + 1);
    localparam int PREF = (NUM_STATES > 2) ? 2 : NUM_STATES - 1;

    t_back_state r_state, n_state;

    logic signed [SCORE_W-1:0] r_path [NUM_STATES];
    logic [27:0]               r_emiss [NUM_STATES];
    logic signed [33:0]        r_cur [NUM_STATES];
    logic signed [16:0]        r_obs;
    logic [KW-1:0]             r_k;
    logic [33:0]               r_sq;
    logic [SW-1:0]             r_sqi;
    logic signed [33:0]        r_best_val;
    logic [SW-1:0]             r_best_idx;
    logic                      r_out_valid;
    t_out_word                 r_out;

    logic signed [17:0] diff;
    logic [16:0]        ad;
    logic [49:0]        prod;
    logic [49:0]        prod_r;
    logic signed [33:0] neg_sp;
    logic signed [33:0] acs [NUM_STATES];
    logic signed [33:0] bv;
    logic [SW-1:0]      bi;
    logic               load_out;

    always_comb begin
        diff   = 18'(r_obs) - 18'(mu_q11(3'(r_k)));
        ad     = diff[17] ? 17'(-diff) : diff[16:0];
        prod   = 50'(r_sq) * 50'(i_cfg.emission_scale);
        prod_r = prod + 50'd2097152;
        neg_sp = -$signed({18'd0, i_cfg.switch_penalty});
        // scores peak at zero, so the best predecessor is the stay or any switch
        for (int k = 0; k < NUM_STATES; k++) begin
            acs[k] = ((34'(r_path[k]) > neg_sp) ? 34'(r_path[k]) : neg_sp)
                     - $signed({6'd0, r_emiss[k]});
        end
        bv = r_cur[PREF];
        bi = SW'(PREF);
        for (int k = 0; k < NUM_STATES; k++) begin
            if (r_cur[k] > bv) begin
                bv = r_cur[k];
                bi = SW'(k);
            end
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            B_IDLE: if (!i_empty) n_state = B_EMIT;
            B_EMIT: if (r_k == KW'(NUM_STATES)) n_state = B_ACS;
            B_ACS:  n_state = B_BEST;
            B_BEST: n_state = B_DONE;
            B_DONE: if (!r_out_valid || i_ready) n_state = B_IDLE;
            default: n_state = B_IDLE;
        endcase
    end

    always_comb begin
        o_pop    = (r_state == B_IDLE) && !i_empty;
        load_out = (r_state == B_DONE) && (!r_out_valid || i_ready);
        o_valid  = r_out_valid;
        o_data   = r_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_out_valid <= 1'b0;
            for (int k = 0; k < NUM_STATES; k++) begin
                r_path[k] <= (k == PREF) ? '0 : INIT_OTHER;
            end
        end else begin
            r_state <= n_state;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            if (o_pop && i_word.first_bin) begin
                for (int k = 0; k < NUM_STATES; k++) begin
                    r_path[k] <= (k == PREF) ? '0 : INIT_OTHER;
                end
            end else if (load_out) begin
                for (int k = 0; k < NUM_STATES; k++) begin
                    if (35'(r_cur[k]) - 35'(r_best_val) < -35'sd2147483648) begin
                        r_path[k] <= 32'sh80000000;
                    end else begin
                        r_path[k] <= 32'(r_cur[k] - r_best_val);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_obs <= i_word.obs;
            r_k   <= '0;
        end
        if (r_state == B_EMIT) begin
            r_k <= r_k + KW'(1);
            if (r_k < KW'(NUM_STATES)) begin
                r_sq  <= 34'(ad) * 34'(ad);
                r_sqi <= SW'(r_k);
            end
            if (r_k != '0) begin
                r_emiss[r_sqi] <= prod_r[49:22];
            end
        end
        if (r_state == B_ACS) begin
            for (int k = 0; k < NUM_STATES; k++) begin
                r_cur[k] <= acs[k];
            end
        end
        if (r_state == B_BEST) begin
            r_best_val <= bv;
            r_best_idx <= bi;
        end
        if (load_out) begin
            r_out.log2_ratio <= r_obs;
            r_out.copy_state <= 3'(r_best_idx);
        end
    end

    a_state_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_data.copy_state < 3'(NUM_STATES)))
        else $error("copy state out of range");

    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_state) == B_DONE)
        else $error("output word without a finished update");

    a_emit_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == B_EMIT |-> r_k <= KW'(NUM_STATES))
        else $error("emission counter overrun");

    a_pop_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> r_state == B_EMIT)
        else $error("pop did not start an update");

endmodule
`default_nettype wire

// File: dv/tb.sv
// Testbench for gc_normalize_hmm_copy_state_core: random and directed genomic bins,
// a local GC-ratio and Viterbi predictor, and a checker on the result channel.
// Depends on gnhc_pkg and the RTL under hdl/.
`default_nettype none
module tb;
    import gnhc_pkg::*;

    localparam int          N_ST        = 6;
    localparam int          PREF        = 2;
    localparam longint      CYCLE_LIMIT = 1000000;
    localparam int          DRAIN_WAIT  = 200;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    t_in_word  in_data = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_out_word out_data;
    logic      cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data = '0;

    gc_normalize_hmm_copy_state_core #(.NUM_STATES(N_ST)) u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .o_in_ready(in_ready), .i_in_data(in_data),
        .o_out_valid(out_valid), .i_out_ready(out_ready), .o_out_data(out_data),
        .i_cfg_wr_en(cfg_wr_en), .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_in_word  bin_q[$];
    t_out_word call_q[$];
    longint    scores[N_ST];
    longint unsigned pen_model, scale_model;
    longint    cyc = 0;
    int        errs = 0;
    int        n_bins = 0;
    int        n_calls = 0;
    int        state_seen[N_ST];

    // state means, Q5.11
    const longint mean_q11[N_ST] = '{-29261, -2048, 0, 1198, 2048, 2707};

    function automatic longint log2_q20(longint unsigned x);
        int p;
        longint unsigned m;
        longint f;
        p = 63;
        f = 0;
        while (p > 0 && x[p] == 1'b0) p--;
        m = (p >= 30) ? (x >> (p - 30)) : (x << (30 - p));
        for (int i = 0; i < 20; i++) begin
            m = (m * m) >> 30;
            f = f << 1;
            if (m >= (64'd1 << 31)) begin
                f = f | 1;
                m = m >> 1;
            end
        end
        return longint'(p) * (64'sd1 << 20) + f;
    endfunction

    function automatic longint gc_ratio_q11(logic [15:0] gc, logic [23:0] depth);
        longint unsigned g, d, e, n, u;
        longint v, r;
        g = 64'(gc);
        d = 64'(depth);
        e = (64'd50 << 16) + g - ((g * g) >> 17);
        if (e < 64'd65536) e = 64'd65536;
        n = ((d * 64'd25600) << 24) / e;
        v = log2_q20(n + 64'd1678) - (64'sd24 << 20) - 64'sd6966590;
        u = longint'(v + (64'sd64 << 20) + 256) >> 9;
        r = longint'(u) - (64'sd64 << 11);
        if (r < -65536) r = -65536;
        if (r > 65535) r = 65535;
        return r;
    endfunction

    task automatic load_initial_scores();
        for (int k = 0; k < N_ST; k++) scores[k] = (k == PREF) ? 0 : -8192;
    endtask

    task automatic decode_bin(input t_in_word w);
        longint obs, diff, emis, mt, s, best_val;
        longint unsigned ad;
        longint cur[N_ST];
        int best;
        t_out_word res;
        if (w.first_bin) load_initial_scores();
        obs = gc_ratio_q11(w.gc_fraction, w.read_depth);
        for (int k = 0; k < N_ST; k++) begin
            diff = obs - mean_q11[k];
            ad = (diff < 0) ? -diff : diff;
            emis = -longint'((scale_model * (ad * ad) + (64'd1 << 21)) >> 22);
            mt = 0;
            for (int j = 0; j < N_ST; j++) begin
                s = scores[j] - ((j == k) ? 0 : longint'(pen_model));
                if (j == 0 || s > mt) mt = s;
            end
            cur[k] = mt + emis;
        end
        best = PREF;
        best_val = cur[PREF];
        for (int k = 0; k < N_ST; k++)
            if (cur[k] > best_val) begin
                best_val = cur[k];
                best = k;
            end
        for (int k = 0; k < N_ST; k++) begin
            s = cur[k] - best_val;
            scores[k] = (s < -64'sd2147483648) ? -64'sd2147483648 : s;
        end
        res.log2_ratio = obs[16:0];
        res.copy_state = best[2:0];
        call_q.push_back(res);
    endtask

    task automatic report(input string what, input longint got, input longint want);
        $display("MISMATCH %s: got %0d want %0d (result %0d)", what, got, want, n_calls);
        errs++;
    endtask

    function automatic logic quiet_stretch();
        return cyc >= 40000 && cyc < 70000;
    endfunction

    always @(posedge i_clk) cyc <= cyc + 1;

    always @(posedge i_clk) begin
        if (cyc >= CYCLE_LIMIT) begin
            $display("timeout at cycle %0d, %0d results outstanding", cyc, call_q.size());
            $display("simulation failed");
            $finish;
        end
    end

    // driver: hand over bins from the pending queue, accept, predict
    always @(posedge i_clk) begin
        logic taken;
        taken = in_valid && in_ready;
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (taken) begin
                decode_bin(in_data);
                n_bins++;
            end
            if (!in_valid || taken) begin
                if (bin_q.size() != 0 && (quiet_stretch() || $urandom_range(99) >= 9)) begin
                    in_valid <= 1'b1;
                    in_data  <= bin_q.pop_front();
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: compare each accepted word with the oldest prediction
    always @(posedge i_clk) begin
        t_out_word want;
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready) begin
                if (call_q.size() == 0) begin
                    report("unexpected word", out_data, 0);
                end else begin
                    want = call_q.pop_front();
                    if (out_data.log2_ratio !== want.log2_ratio)
                        report("log2_ratio", out_data.log2_ratio, want.log2_ratio);
                    if (out_data.copy_state !== want.copy_state)
                        report("copy_state", out_data.copy_state, want.copy_state);
                    if (want.copy_state < N_ST) state_seen[want.copy_state]++;
                end
                n_calls++;
            end
            out_ready <= quiet_stretch() || $urandom_range(99) >= 9;
        end
    end

    task automatic wait_drained();
        do @(negedge i_clk);
        while (bin_q.size() != 0 || in_valid || call_q.size() != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(posedge i_clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        if (idx == CFG_SWITCH_PENALTY) pen_model = 64'(val);
        else if (idx == CFG_EMISSION_SCALE) scale_model = 64'(val);
        @(posedge i_clk);
        cfg_wr_en <= 1'b0;
    endtask

    function automatic t_in_word mk_bin(logic [15:0] g, logic [23:0] d, logic fb);
        t_in_word w;
        w.gc_fraction = g;
        w.read_depth  = d;
        w.first_bin   = fb;
        return w;
    endfunction

    // runs of bins around a copy level that now and then changes, started by a first bin, plus noise
    task automatic queue_random(input int count);
        int left, lvl, run;
        longint dep;
        left = count;
        while (left > 0) begin
            if ($urandom_range(99) < 15) begin
                bin_q.push_back(mk_bin(16'($urandom), 24'($urandom), 1'($urandom_range(1))));
                left--;
            end else begin
                run = $urandom_range(40, 4);
                for (int i = 0; i < run && left > 0; i++) begin
                    if (i == 0 || $urandom_range(99) < 10) lvl = $urandom_range(N_ST - 1);
                    dep = 64'd6400 * lvl + $urandom_range(1600);
                    dep = dep * $urandom_range(140, 70) / 100;
                    bin_q.push_back(mk_bin(16'($urandom_range(42000, 20000)), dep[23:0],
                                           i == 0));
                    left--;
                end
            end
        end
    endtask

    initial begin
        pen_model   = 64'(SWITCH_PENALTY_RST);
        scale_model = 64'(EMISSION_SCALE_RST);
        load_initial_scores();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed bins at the reset settings
        bin_q.push_back(mk_bin(16'd0, 24'd0, 1'b1));
        bin_q.push_back(mk_bin(16'hFFFF, 24'hFFFFFF, 1'b0));
        bin_q.push_back(mk_bin(16'hFFFF, 24'd0, 1'b0));
        bin_q.push_back(mk_bin(16'd0, 24'hFFFFFF, 1'b0));
        bin_q.push_back(mk_bin(16'd32768, 24'd1, 1'b0));
        for (int k = 0; k < N_ST; k++)
            for (int r = 0; r < 3; r++)
                bin_q.push_back(mk_bin(16'd0, 24'(6400 * k), r == 0 && k == 3));
        bin_q.push_back(mk_bin(16'd0, 24'd12800, 1'b1));
        bin_q.push_back(mk_bin(16'h8000, 24'd6400, 1'b0));
        wait_drained();

        write_reg(CFG_SWITCH_PENALTY, 16'd0);
        write_reg(CFG_EMISSION_SCALE, 16'd0);
        bin_q.push_back(mk_bin(16'd0, 24'd19200, 1'b1));
        queue_random(300);
        wait_drained();

        write_reg(CFG_SWITCH_PENALTY, 16'hFFFF);
        write_reg(CFG_EMISSION_SCALE, 16'hFFFF);
        queue_random(300);
        wait_drained();

        write_reg(CFG_SPARE_A, 16'h1234);
        write_reg(CFG_SPARE_B, 16'hFFFF);
        write_reg(CFG_SWITCH_PENALTY, 16'd0);
        queue_random(300);
        wait_drained();

        for (int ph = 0; ph < 3; ph++) begin
            write_reg(CFG_SWITCH_PENALTY, 16'($urandom));
            write_reg(CFG_EMISSION_SCALE, 16'($urandom_range(40000)));
            queue_random(250);
            wait_drained();
        end

        write_reg(CFG_SWITCH_PENALTY, SWITCH_PENALTY_RST);
        write_reg(CFG_EMISSION_SCALE, EMISSION_SCALE_RST);
        queue_random(275);
        wait_drained();
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("covered %0d bins, %0d results checked over 8 register settings",
                 n_bins, n_calls);
        $display("best states seen: %0d %0d %0d %0d %0d %0d", state_seen[0], state_seen[1],
                 state_seen[2], state_seen[3], state_seen[4], state_seen[5]);
        if (errs == 0 && call_q.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
`default_nettype wire
